/* rtl/ril_pkg.sv */
`timescale 1ns / 1ps
// Package for the rank indexed list: sizes, operation codes and the
// memory write port type. Used by every other file of the block.
package ril_pkg;

	localparam int DEPTH  = 64;
	localparam int WIDTH  = 32;

	localparam int OP_W   = 2;
	localparam int RANK_W = 7;
	localparam int VAL_W  = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CMP_W  = (RANK_W > CNT_W) ? RANK_W : CNT_W;

	localparam logic [OP_W-1:0] OP_GET     = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT  = 2'd1;
	localparam logic [OP_W-1:0] OP_REPLACE = 2'd2;
	localparam logic [OP_W-1:0] OP_REMOVE  = 2'd3;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [WIDTH-1:0]  data;
	} mem_wr_t;

endpackage

/* rtl/ril_in_if.sv */
`timescale 1ns / 1ps
// Request channel of the rank indexed list: valid, ready and one
// operation word. Depends on ril_pkg.
interface ril_in_if;
	import ril_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [RANK_W-1:0] rank;
	logic [VAL_W-1:0]  item_value;

	modport source (output valid, output operation, output rank, output item_value,
		input ready);
	modport sink (input valid, input operation, input rank, input item_value,
		output ready);

endinterface

/* rtl/ril_out_if.sv */
`timescale 1ns / 1ps
// Response channel of the rank indexed list: valid, ready and one
// result word. Depends on ril_pkg.
interface ril_out_if;
	import ril_pkg::*;

	logic             valid;
	logic             ready;
	logic             success;
	logic [VAL_W-1:0] read_value;
	logic [CNT_W-1:0] entry_count;
	logic             empty_flag;

	modport source (output valid, output success, output read_value,
		output entry_count, output empty_flag, input ready);
	modport sink (input valid, input success, input read_value,
		input entry_count, input empty_flag, output ready);

endinterface

/* rtl/rank_indexed_list.sv */
`timescale 1ns / 1ps
// Top level of the rank indexed list: request decode, shift sequencer
// and result register. Depends on ril_pkg, ril_in_if, ril_out_if, ril_mem.
//
// Each request word carries an operation (get, insert, replace, remove),
// a rank and a value. Each accepted word yields exactly one response word
// with success, the value read, the entry count after the operation and
// an empty flag. The list lives in a single memory with one read and one
// write port; insert and remove move the later entries one per cycle.
// Replace, a failed request and an insert at the end finish without a
// read; get reads the entry at the rank; a remove reads the count - rank
// entries from the rank on and moves all but the first down; an insert
// moves the entries from the rank on up and then writes the value. The
// block takes one request at a time and is ready again the cycle after
// the response is loaded. The response register frees the receiver
// from the sequencer: a new request is taken while a response waits; a
// finished request holds until the response register is free. Reset
// empties the list; the memory contents are not cleared.
module rank_indexed_list (
	input logic clk,
	input logic arst_n,
	ril_in_if.sink   req,
	ril_out_if.source rsp
);
	import ril_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_FINAL = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cnt_new_q;
	logic [OP_W-1:0]   op_q;
	logic [ADDR_W-1:0] rank_q;
	logic [WIDTH-1:0]  val_q;
	logic              ok_q;
	logic              append_q;
	logic [ADDR_W-1:0] ptr_q;
	logic [ADDR_W-1:0] src_q;
	logic              pend_q;
	logic [WIDTH-1:0]  rd_q;
	logic              out_valid_q;

	logic [CMP_W-1:0]  r_ext;
	logic [CMP_W-1:0]  c_ext;
	logic              in_range;
	logic              ins_ok;
	logic              acc;
	logic              last_rd;
	logic              cap;
	logic              pend_wr;
	logic              out_free;
	mem_wr_t           wr;
	logic [ADDR_W-1:0] raddr;
	logic [WIDTH-1:0]  rdata;

	ril_mem u_mem (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign r_ext     = CMP_W'(req.rank);
	assign c_ext     = CMP_W'(count_q);
	assign in_range  = r_ext < c_ext;
	assign ins_ok    = (r_ext <= c_ext) && (c_ext < CMP_W'(DEPTH));
	assign out_free  = !out_valid_q || rsp.ready;

	always_comb begin
		unique case (op_q)
			OP_INSERT: last_rd = (ptr_q == rank_q);
			OP_REMOVE: last_rd = (CNT_W'(ptr_q) == count_q - CNT_W'(1));
			default:   last_rd = 1'b1;
		endcase
	end

	assign cap     = pend_q && ((op_q == OP_GET) || ((op_q == OP_REMOVE) && (src_q == rank_q)));
	assign pend_wr = pend_q && !cap;
	assign raddr   = ptr_q;

	always_comb begin
		wr.en   = 1'b0;
		wr.addr = rank_q;
		wr.data = val_q;
		if (state_q == ST_START) begin
			wr.en = ok_q && ((op_q == OP_REPLACE) || ((op_q == OP_INSERT) && append_q));
		end else if (state_q == ST_FINAL) begin
			wr.en = 1'b1;
		end else if ((state_q == ST_SHIFT) || (state_q == ST_DRAIN)) begin
			wr.en   = pend_wr;
			wr.data = rdata;
			wr.addr = (op_q == OP_INSERT) ? src_q + ADDR_W'(1) : src_q - ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					pend_q <= 1'b0;
					if (acc) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (!ok_q || (op_q == OP_REPLACE) || ((op_q == OP_INSERT) && append_q)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					pend_q <= 1'b1;
					if (last_rd) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					pend_q  <= 1'b0;
					state_q <= (op_q == OP_INSERT) ? ST_FINAL : ST_DONE;
				end
				ST_FINAL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						count_q <= cnt_new_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q     <= req.operation;
			rank_q   <= req.rank[ADDR_W-1:0];
			val_q    <= req.item_value[WIDTH-1:0];
			append_q <= (r_ext == c_ext);
			rd_q     <= '0;
			unique case (req.operation)
				OP_INSERT: begin
					ok_q      <= ins_ok;
					cnt_new_q <= ins_ok ? count_q + CNT_W'(1) : count_q;
				end
				OP_REMOVE: begin
					ok_q      <= in_range;
					cnt_new_q <= in_range ? count_q - CNT_W'(1) : count_q;
				end
				default: begin
					ok_q      <= in_range;
					cnt_new_q <= count_q;
				end
			endcase
		end
		if (state_q == ST_START) begin
			ptr_q <= (op_q == OP_INSERT) ? ADDR_W'(count_q - CNT_W'(1)) : rank_q;
		end
		if (state_q == ST_SHIFT) begin
			src_q <= ptr_q;
			if (!last_rd) begin
				ptr_q <= (op_q == OP_INSERT) ? ptr_q - ADDR_W'(1) : ptr_q + ADDR_W'(1);
			end
		end
		if (cap && ((state_q == ST_SHIFT) || (state_q == ST_DRAIN))) begin
			rd_q <= rdata;
		end
		if ((state_q == ST_DONE) && out_free) begin
			rsp.success     <= ok_q;
			rsp.read_value  <= VAL_W'(rd_q);
			rsp.entry_count <= cnt_new_q;
			rsp.empty_flag  <= (cnt_new_q == '0);
		end
	end

	assign rsp.valid = out_valid_q;

endmodule

/* rtl/ril_mem.sv */
`timescale 1ns / 1ps
// Entry store of the rank indexed list: one write port and one read
// port with registered read data. Depends on ril_pkg.
module ril_mem (
	input  logic                     clk,
	input  ril_pkg::mem_wr_t         wr,
	input  logic [ril_pkg::ADDR_W-1:0] raddr,
	output logic [ril_pkg::WIDTH-1:0]  rdata
);
	import ril_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
